FILE: rtl/core/pixel_depth_converter_core_assert.svh
// Assertion macros for the pixel depth converter core.
`ifndef PIXEL_DEPTH_CONVERTER_CORE_ASSERT_SVH
`define PIXEL_DEPTH_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PDC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdc: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define PDC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdc: next-cycle check failed");
`else
`define PDC_ASSERT_IMP(label, clk, rst, ante, cons)
`define PDC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/pdc_pkg.sv
// Shared types and constants for the pixel depth converter.
`timescale 1ns / 1ps
package pdc_pkg;

  localparam int unsigned FmtW      = 3;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 5;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned PosW      = 3;

  // Pixel format codes
  localparam logic [FmtW-1:0] FMT_U1  = 3'd0;
  localparam logic [FmtW-1:0] FMT_U8  = 3'd1;
  localparam logic [FmtW-1:0] FMT_U16 = 3'd2;
  localparam logic [FmtW-1:0] FMT_S16 = 3'd3;
  localparam logic [FmtW-1:0] FMT_U32 = 3'd4;
  localparam logic [FmtW-1:0] FMT_S32 = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_SOURCE_FORMAT    = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_DEST_FORMAT      = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_SATURATE_MODE    = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_SHIFT_AMOUNT     = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_FIRST_BIT_OFFSET = 3'd4;

  localparam logic [7:0] FULL_MASK = 8'hFF;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        row_end;
  } pdc_in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [7:0]  bit_mask;
  } pdc_out_t;

  // Conversion datapath result for one request
  typedef struct packed {
    logic        produce;    // plain conversion gives a result
    logic        pack_step;  // 1-bit output: feed the packer
    logic        flag;
    logic [31:0] value;
  } pdc_conv_t;

  // Packer view of the current request
  typedef struct packed {
    logic       emit;
    logic [7:0] pack_byte;
    logic [7:0] pack_mask;
  } pdc_pack_t;

endpackage

FILE: rtl/core/pdc_convert.sv
// Combinational format conversion: shift, wrap or saturate, and 1-bit flag.
`timescale 1ns / 1ps
module pdc_convert (
  input  logic [31:0]                  pixel_value,
  input  logic [pdc_pkg::FmtW-1:0]     source_format,
  input  logic [pdc_pkg::FmtW-1:0]     dest_format,
  input  logic                         saturate_mode,
  input  logic [pdc_pkg::ShiftW-1:0]   shift_amount,
  output pdc_pkg::pdc_conv_t           conv
);
  import pdc_pkg::*;

  logic [31:0]        u8v;
  logic [31:0]        u16v;
  logic [31:0]        s16v;
  logic [31:0]        shl_u8;
  logic [31:0]        shl_u16;
  logic [31:0]        shl_s16;
  logic [31:0]        shr_u16;
  logic [31:0]        shr_u32;
  logic signed [31:0] sar_s16;
  logic signed [31:0] sar_s32;
  logic [7:0]         u16_to_u8;
  logic [7:0]         u32_to_u8;
  logic [15:0]        u32_to_u16;
  logic [7:0]         s16_to_u8;
  logic [15:0]        s32_to_s16;
  logic [31:0]        expand;

  always_comb begin
    u8v  = {24'd0, pixel_value[7:0]};
    u16v = {16'd0, pixel_value[15:0]};
    s16v = {{16{pixel_value[15]}}, pixel_value[15:0]};

    shl_u8  = u8v << shift_amount;
    shl_u16 = u16v << shift_amount;
    shl_s16 = s16v << shift_amount;
    shr_u16 = u16v >> shift_amount;
    shr_u32 = pixel_value >> shift_amount;
    sar_s16 = $signed(s16v) >>> shift_amount;
    sar_s32 = $signed(pixel_value) >>> shift_amount;

    u16_to_u8 = (saturate_mode && (|shr_u16[31:8])) ? 8'hFF : shr_u16[7:0];
    u32_to_u8 = (saturate_mode && (|shr_u32[31:8])) ? 8'hFF : shr_u32[7:0];
    u32_to_u16 = (saturate_mode && (|shr_u32[31:16])) ? 16'hFFFF : shr_u32[15:0];

    // In saturate mode, clamp negatives to zero and large positives to the byte maximum
    if (!saturate_mode) begin
      s16_to_u8 = sar_s16[7:0];
    end else if (sar_s16[31]) begin
      s16_to_u8 = 8'd0;
    end else if (|sar_s16[30:8]) begin
      s16_to_u8 = 8'hFF;
    end else begin
      s16_to_u8 = sar_s16[7:0];
    end

    // In range for S16 when bits 31..15 are all sign copies
    if (!saturate_mode || (&sar_s32[31:15]) || !(|sar_s32[31:15])) begin
      s32_to_s16 = sar_s32[15:0];
    end else begin
      s32_to_s16 = sar_s32[31] ? 16'h8000 : 16'h7FFF;
    end

    expand = {32{pixel_value[0]}};

    conv = '0;
    if (dest_format == FMT_U1) begin
      case (source_format)
        FMT_U8: begin
          conv.pack_step = 1'b1;
          conv.flag      = |pixel_value[7:0];
        end
        FMT_U16, FMT_S16: begin
          conv.pack_step = 1'b1;
          conv.flag      = |pixel_value[15:0];
        end
        FMT_U32: begin
          conv.pack_step = 1'b1;
          conv.flag      = |pixel_value;
        end
        default: conv.pack_step = 1'b0;
      endcase
    end else begin
      case (source_format)
        FMT_U1: begin
          case (dest_format)
            FMT_U8:           conv.value = {24'd0, expand[7:0]};
            FMT_U16, FMT_S16: conv.value = {16'd0, expand[15:0]};
            FMT_U32:          conv.value = expand;
            default:          conv.value = '0;
          endcase
          conv.produce = (dest_format == FMT_U8) || (dest_format == FMT_U16) ||
                         (dest_format == FMT_S16) || (dest_format == FMT_U32);
        end
        FMT_U8: begin
          case (dest_format)
            FMT_U16, FMT_S16: conv.value = {16'd0, shl_u8[15:0]};
            FMT_U32:          conv.value = shl_u8;
            default:          conv.value = '0;
          endcase
          conv.produce = (dest_format == FMT_U16) || (dest_format == FMT_S16) ||
                         (dest_format == FMT_U32);
        end
        FMT_U16: begin
          case (dest_format)
            FMT_U32: conv.value = shl_u16;
            FMT_U8:  conv.value = {24'd0, u16_to_u8};
            default: conv.value = '0;
          endcase
          conv.produce = (dest_format == FMT_U32) || (dest_format == FMT_U8);
        end
        FMT_S16: begin
          case (dest_format)
            FMT_S32: conv.value = shl_s16;
            FMT_U8:  conv.value = {24'd0, s16_to_u8};
            default: conv.value = '0;
          endcase
          conv.produce = (dest_format == FMT_S32) || (dest_format == FMT_U8);
        end
        FMT_U32: begin
          case (dest_format)
            FMT_U8:  conv.value = {24'd0, u32_to_u8};
            FMT_U16: conv.value = {16'd0, u32_to_u16};
            default: conv.value = '0;
          endcase
          conv.produce = (dest_format == FMT_U8) || (dest_format == FMT_U16);
        end
        FMT_S32: begin
          conv.value   = {16'd0, s32_to_s16};
          conv.produce = (dest_format == FMT_S16);
        end
        default: conv.produce = 1'b0;
      endcase
    end
  end

endmodule

FILE: rtl/core/pdc_packer.sv
// Bit packer for 1-bit output: collects flags into a byte with a valid mask.
`timescale 1ns / 1ps
module pdc_packer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       flag,
  input  logic                       row_end,
  input  logic                       offset_write,
  input  logic [pdc_pkg::PosW-1:0]   offset_data,
  input  logic [pdc_pkg::PosW-1:0]   first_bit_offset,
  output pdc_pkg::pdc_pack_t         pack
);
  import pdc_pkg::*;

  logic [7:0]      pack_byte;
  logic [7:0]      pack_mask;
  logic [PosW-1:0] bit_position;
  logic [7:0]      bit_sel;

  always_comb begin
    bit_sel        = 8'd1 << bit_position;
    pack.pack_byte = flag ? (pack_byte | bit_sel) : (pack_byte & ~bit_sel);
    pack.pack_mask = pack_mask | bit_sel;
    pack.emit      = (bit_position == PosW'(7)) || row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_byte    <= '0;
      pack_mask    <= '0;
      bit_position <= '0;
    end else if (offset_write) begin
      // New offset restarts the row and drops any partial byte
      pack_byte    <= '0;
      pack_mask    <= '0;
      bit_position <= offset_data;
    end else if (step) begin
      if (pack.emit) begin
        pack_byte    <= '0;
        pack_mask    <= '0;
        bit_position <= row_end ? first_bit_offset : '0;
      end else begin
        pack_byte    <= pack.pack_byte;
        pack_mask    <= pack.pack_mask;
        bit_position <= bit_position + PosW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/pixel_depth_converter_core.sv
// Pixel depth converter top level: config registers, input and result stages.
//
//   Channel   Direction  Handshake              Payload
//   in        sink       in_valid / in_ready    in_data  (pdc_in_t)
//   out       source     out_valid / out_ready  out_data (pdc_out_t)
//   cfg       sink       cfg_write              cfg_index, cfg_data
//
// One pixel per clock unless the result register stalls: a request is converted in the
// input stage and lands in the result register at the edge after accept, if not stalled.
// Both stages advance together whenever the result register is empty or being taken.
// Reset (rst, synchronous) clears both stages and the packer, and loads the
// register reset values. A 1-bit destination emits a byte when its top bit
// fills or at row end; other pixels of that row give no result.
`timescale 1ns / 1ps
`include "pixel_depth_converter_core_assert.svh"
module pixel_depth_converter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pdc_pkg::pdc_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pdc_pkg::pdc_out_t               out_data,
  input  logic                            cfg_write,
  input  logic [pdc_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [pdc_pkg::CfgDataW-1:0]    cfg_data
);
  import pdc_pkg::*;

  logic [FmtW-1:0]   source_format;
  logic [FmtW-1:0]   dest_format;
  logic              saturate_mode;
  logic [ShiftW-1:0] shift_amount;
  logic [PosW-1:0]   first_bit_offset;

  logic              s1_valid;
  pdc_in_t           s1_data;
  logic              out_free;
  logic              s1_adv;
  logic              offset_write;
  pdc_conv_t         conv;
  pdc_pack_t         pack;

  assign out_free     = !out_valid || out_ready;
  assign s1_adv       = s1_valid && out_free;
  assign in_ready     = !s1_valid || out_free;
  assign offset_write = cfg_write && (cfg_index == REG_FIRST_BIT_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format    <= FMT_U8;
      dest_format      <= FMT_U16;
      saturate_mode    <= 1'b0;
      shift_amount     <= '0;
      first_bit_offset <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_FORMAT:    source_format    <= cfg_data[FmtW-1:0];
        REG_DEST_FORMAT:      dest_format      <= cfg_data[FmtW-1:0];
        REG_SATURATE_MODE:    saturate_mode    <= cfg_data[0];
        REG_SHIFT_AMOUNT:     shift_amount     <= cfg_data[ShiftW-1:0];
        REG_FIRST_BIT_OFFSET: first_bit_offset <= cfg_data[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  pdc_convert u_convert (
    .pixel_value   (s1_data.pixel_value),
    .source_format (source_format),
    .dest_format   (dest_format),
    .saturate_mode (saturate_mode),
    .shift_amount  (shift_amount),
    .conv          (conv)
  );

  pdc_packer u_packer (
    .clk              (clk),
    .rst              (rst),
    .step             (s1_adv && conv.pack_step),
    .flag             (conv.flag),
    .row_end          (s1_data.row_end),
    .offset_write     (offset_write),
    .offset_data      (cfg_data[PosW-1:0]),
    .first_bit_offset (first_bit_offset),
    .pack             (pack)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && (conv.produce || (conv.pack_step && pack.emit));
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (conv.pack_step) begin
        out_data.result_value <= {24'd0, pack.pack_byte};
        out_data.bit_mask     <= pack.pack_mask;
      end else begin
        out_data.result_value <= conv.value;
        out_data.bit_mask     <= FULL_MASK;
      end
    end
  end

  // Every result carries at least one valid bit
  `PDC_ASSERT_IMP(a_mask_nonzero, clk, rst, out_valid, out_data.bit_mask != 8'd0)
  // Packed bytes have clear upper result bits
  `PDC_ASSERT_IMP(a_packed_narrow, clk, rst, out_valid && (out_data.bit_mask != FULL_MASK),
                  out_data.result_value[31:8] == 24'd0)
  // A stalled input stage keeps its request
  `PDC_ASSERT_NXT(a_s1_hold, clk, rst, s1_valid && !out_free,
                  s1_valid && $stable(s1_data))

endmodule

FILE: tb/pixel_depth_converter_checker.sv
// Result predictor and scoreboard for the pixel depth converter.
`timescale 1ns / 1ps
module pixel_depth_converter_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  pdc_pkg::pdc_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  pdc_pkg::pdc_out_t             out_data,
  input  logic                          cfg_write,
  input  logic [pdc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pdc_pkg::CfgDataW-1:0]  cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import pdc_pkg::*;

  // Shadow registers and packer state
  logic [FmtW-1:0]   src_fmt;
  logic [FmtW-1:0]   dst_fmt;
  logic              sat_on;
  logic [ShiftW-1:0] shamt;
  logic [PosW-1:0]   row_offset;
  logic [7:0]        pack_bits;
  logic [7:0]        pack_valid;
  logic [PosW-1:0]   pack_pos;

  pdc_out_t expected_results[$];

  function automatic logic [31:0] clamp_unsigned(input logic [31:0] v, input logic [31:0] limit);
    if (sat_on) return (v > limit) ? limit : v;
    return v & limit;
  endfunction

  task automatic convert_pixel(input pdc_in_t req, output bit emit, output pdc_out_t res);
    logic [31:0]        pv;
    logic [63:0]        wide;
    logic signed [31:0] sv;
    logic               flag;
    bit                 packs;
    pv = req.pixel_value;
    emit = 1'b1;
    res.result_value = '0;
    res.bit_mask = FULL_MASK;
    if (dst_fmt == FMT_U1) begin
      packs = 1'b1;
      flag = 1'b0;
      case (src_fmt)
        FMT_U8: flag = (pv[7:0] != 0);
        FMT_U16, FMT_S16: flag = (pv[15:0] != 0);
        FMT_U32: flag = (pv != 0);
        default: packs = 1'b0;
      endcase
      if (!packs) begin
        emit = 1'b0;
      end else begin
        pack_bits[pack_pos] = flag;
        pack_valid[pack_pos] = 1'b1;
        if (pack_pos == 3'd7 || req.row_end) begin
          res.result_value = {24'h0, pack_bits};
          res.bit_mask = pack_valid;
          pack_bits = '0;
          pack_valid = '0;
          pack_pos = req.row_end ? row_offset : 3'd0;
        end else begin
          emit = 1'b0;
          pack_pos = pack_pos + 3'd1;
        end
      end
    end else begin
      case (src_fmt)
        FMT_U1: begin
          case (dst_fmt)
            FMT_U8: res.result_value = pv[0] ? 32'h0000_00FF : '0;
            FMT_U16, FMT_S16: res.result_value = pv[0] ? 32'h0000_FFFF : '0;
            FMT_U32: res.result_value = pv[0] ? 32'hFFFF_FFFF : '0;
            default: emit = 1'b0;
          endcase
        end
        FMT_U8: begin
          wide = {56'h0, pv[7:0]} << shamt;
          case (dst_fmt)
            FMT_U16, FMT_S16: res.result_value = {16'h0, wide[15:0]};
            FMT_U32: res.result_value = wide[31:0];
            default: emit = 1'b0;
          endcase
        end
        FMT_U16: begin
          wide = {48'h0, pv[15:0]} << shamt;
          case (dst_fmt)
            FMT_U32: res.result_value = wide[31:0];
            FMT_U8: res.result_value = clamp_unsigned({16'h0, pv[15:0]} >> shamt, 32'hFF);
            default: emit = 1'b0;
          endcase
        end
        FMT_S16: begin
          wide = {32'h0, {16{pv[15]}}, pv[15:0]} << shamt;
          sv = $signed({{16{pv[15]}}, pv[15:0]}) >>> shamt;
          case (dst_fmt)
            FMT_S32: res.result_value = wide[31:0];
            FMT_U8: begin
              if (!sat_on) res.result_value = {24'h0, sv[7:0]};
              else if (sv < 0) res.result_value = '0;
              else if (sv > 255) res.result_value = 32'hFF;
              else res.result_value = $unsigned(sv);
            end
            default: emit = 1'b0;
          endcase
        end
        FMT_U32: begin
          case (dst_fmt)
            FMT_U8: res.result_value = clamp_unsigned(pv >> shamt, 32'hFF);
            FMT_U16: res.result_value = clamp_unsigned(pv >> shamt, 32'hFFFF);
            default: emit = 1'b0;
          endcase
        end
        FMT_S32: begin
          sv = $signed(pv) >>> shamt;
          if (dst_fmt != FMT_S16) emit = 1'b0;
          else if (!sat_on) res.result_value = {16'h0, sv[15:0]};
          else if (sv < -32768) res.result_value = 32'h8000;
          else if (sv > 32767) res.result_value = 32'h7FFF;
          else res.result_value = {16'h0, sv[15:0]};
        end
        default: emit = 1'b0;
      endcase
    end
  endtask

  always @(posedge clk) begin
    pdc_out_t want;
    bit       has_result;
    if (rst) begin
      src_fmt = FMT_U8;
      dst_fmt = FMT_U16;
      sat_on = 1'b0;
      shamt = '0;
      row_offset = '0;
      pack_bits = '0;
      pack_valid = '0;
      pack_pos = '0;
      expected_results.delete();
    end else begin
      // Retire results before predicting: a result never belongs to a same-edge request
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result value %h mask %h", $realtime,
                     out_data.result_value, out_data.bit_mask);
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_value !== want.result_value ||
              out_data.bit_mask !== want.bit_mask) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch value exp %h got %h, mask exp %h got %h", $realtime,
                       want.result_value, out_data.result_value,
                       want.bit_mask, out_data.bit_mask);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE_FORMAT: src_fmt = cfg_data[FmtW-1:0];
          REG_DEST_FORMAT: dst_fmt = cfg_data[FmtW-1:0];
          REG_SATURATE_MODE: sat_on = cfg_data[0];
          REG_SHIFT_AMOUNT: shamt = cfg_data[ShiftW-1:0];
          REG_FIRST_BIT_OFFSET: begin
            // Drop any partly packed byte and restart the row
            row_offset = cfg_data[PosW-1:0];
            pack_pos = row_offset;
            pack_bits = '0;
            pack_valid = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        convert_pixel(in_data, has_result, want);
        if (has_result) expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/pixel_depth_converter_core_tb.sv
// Stimulus and verdict for the pixel depth converter core.
`timescale 1ns / 1ps
module pixel_depth_converter_core_tb;
  import pdc_pkg::*;

  // Supported source/destination pairs, six bits each
  localparam logic [18*6-1:0] PAIR_LIST = {
    FMT_U1, FMT_U8, FMT_U1, FMT_U16, FMT_U1, FMT_S16, FMT_U1, FMT_U32,
    FMT_U8, FMT_U1, FMT_U8, FMT_U16, FMT_U8, FMT_S16, FMT_U8, FMT_U32,
    FMT_U16, FMT_U1, FMT_U16, FMT_U8, FMT_U16, FMT_U32,
    FMT_S16, FMT_U1, FMT_S16, FMT_U8, FMT_S16, FMT_S32,
    FMT_U32, FMT_U1, FMT_U32, FMT_U8, FMT_U32, FMT_U16,
    FMT_S32, FMT_S16
  };

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  pdc_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pdc_out_t             out_data;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  int                   fail_count;
  int                   pending;
  int unsigned          tx_idle_pct;
  int unsigned          rx_idle_pct;

  pixel_depth_converter_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_depth_converter_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the accept
  task automatic send_pixel(input logic [31:0] pv, input logic re);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pixel_value: pv, row_end: re};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold requests until every result is out, then let the pipeline empty
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      3: return $urandom & 32'h0000_FFFF;
      4: return 32'h1 << $urandom_range(0, 31);
      5: return $urandom | 32'h8000_8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setup(output bit counts);
    logic [5:0]        pair;
    logic [FmtW-1:0]   sf;
    logic [FmtW-1:0]   df;
    logic [ShiftW-1:0] sh;
    if ($urandom_range(0, 9) < 8) begin
      pair = PAIR_LIST[6 * $urandom_range(0, 17) +: 6];
      sf = pair[5:3];
      df = pair[2:0];
      counts = 1'b1;
    end else begin
      sf = FmtW'($urandom_range(0, 7));
      df = FmtW'($urandom_range(0, 7));
      counts = 1'b0;
    end
    case ($urandom_range(0, 3))
      0: sh = '0;
      1: sh = 5'd31;
      2: sh = ShiftW'($urandom_range(0, 31));
      default: sh = ShiftW'($urandom_range(1, 8));
    endcase
    write_reg(REG_SOURCE_FORMAT, CfgDataW'(sf));
    write_reg(REG_DEST_FORMAT, CfgDataW'(df));
    write_reg(REG_SATURATE_MODE, CfgDataW'($urandom_range(0, 1)));
    write_reg(REG_SHIFT_AMOUNT, CfgDataW'(sh));
    if ($urandom_range(0, 1) == 0)
      write_reg(REG_FIRST_BIT_OFFSET, CfgDataW'($urandom_range(0, 7)));
  endtask

  initial begin
    int          phase;
    int          seg_len;
    int unsigned counted;
    bit          counts;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_pct = 38;
    rx_idle_pct = 46;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset formats are U8 to U16; row end has no effect here
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0, 1'b0);
    wait_drain();
    // 1-bit expansion ignores the shift
    write_reg(REG_SOURCE_FORMAT, CfgDataW'(FMT_U1));
    write_reg(REG_DEST_FORMAT, CfgDataW'(FMT_S16));
    write_reg(REG_SHIFT_AMOUNT, 5'd31);
    send_pixel(32'h1, 1'b0);
    send_pixel(32'hFFFF_FFFE, 1'b0);
    wait_drain();
    // Wide left shift keeps only the low bits
    write_reg(REG_SOURCE_FORMAT, CfgDataW'(FMT_U8));
    write_reg(REG_DEST_FORMAT, CfgDataW'(FMT_U32));
    send_pixel(32'hFF, 1'b0);
    wait_drain();
    // Signed saturation at both ends
    write_reg(REG_SOURCE_FORMAT, CfgDataW'(FMT_S32));
    write_reg(REG_DEST_FORMAT, CfgDataW'(FMT_S16));
    write_reg(REG_SATURATE_MODE, 5'd1);
    write_reg(REG_SHIFT_AMOUNT, 5'd0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b0);
    wait_drain();
    write_reg(REG_SOURCE_FORMAT, CfgDataW'(FMT_S16));
    write_reg(REG_DEST_FORMAT, CfgDataW'(FMT_U8));
    send_pixel(32'h0000_8000, 1'b0);
    send_pixel(32'h0000_7FFF, 1'b0);
    wait_drain();
    // Equal formats give nothing
    write_reg(REG_SOURCE_FORMAT, CfgDataW'(FMT_U16));
    write_reg(REG_DEST_FORMAT, CfgDataW'(FMT_U16));
    send_pixel(32'h1234, 1'b0);
    wait_drain();
    // Packing from a nonzero offset: a byte filled up to its top bit, then a short row
    write_reg(REG_SOURCE_FORMAT, CfgDataW'(FMT_U32));
    write_reg(REG_DEST_FORMAT, CfgDataW'(FMT_U1));
    write_reg(REG_FIRST_BIT_OFFSET, 5'd5);
    send_pixel(32'h1, 1'b0);
    send_pixel(32'h0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'h0, 1'b1);
    wait_drain();
    // Leave a byte partly filled across a format change
    write_reg(REG_SOURCE_FORMAT, CfgDataW'(FMT_U16));
    send_pixel(32'h0001_0000, 1'b0);
    wait_drain();
    write_reg(REG_DEST_FORMAT, CfgDataW'(FMT_U8));
    send_pixel(32'h1FF, 1'b0);
    wait_drain();
    write_reg(REG_DEST_FORMAT, CfgDataW'(FMT_U1));
    send_pixel(32'hFFFF, 1'b0);
    send_pixel(32'h0, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 38; rx_idle_pct = 46; end
        1: begin tx_idle_pct = 46; rx_idle_pct = 38; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      counted = 0;
      while (counted < 170) begin
        wait_drain();
        random_setup(counts);
        seg_len = counts ? $urandom_range(8, 40) : $urandom_range(2, 6);
        repeat (seg_len) begin
          send_pixel(random_pixel(), $urandom_range(0, 6) == 0);
          if (counts) counted++;
          if ($urandom_range(0, 59) == 0) wait_drain();
        end
      end
    end

    wait_drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
